>>> sv/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent implication checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> sv/cfb_pkg.sv
`timescale 1ns / 1ps

package cfb_pkg;

  localparam logic [7:0]  SOF_BYTE   = 8'h7F;
  localparam logic [7:0]  SEQ_SET    = 8'h80;
  localparam logic [7:0]  SEQ_CLEAR  = 8'h00;
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_TOPBIT = 16'h8000;

  // Up to six bytes leave for one input transaction.
  localparam int BUF_DEPTH = 6;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       resync;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } out_item_t;

  // One group of bytes handed to the emit buffer; eof marks the last entry.
  typedef struct packed {
    logic [BUF_DEPTH-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      eof;
  } emit_load_t;

  typedef struct packed {
    logic free;
  } emit_status_t;

  // CRC-16, polynomial 0x8005, one byte MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the sequence byte, for either value of the toggle.
  localparam logic [15:0] CRC_AFTER_SEQ_SET   = crc_byte(CRC_SEED, SEQ_SET);
  localparam logic [15:0] CRC_AFTER_SEQ_CLEAR = crc_byte(CRC_SEED, SEQ_CLEAR);

endpackage

>>> sv/cfb_emit_buf.sv
`timescale 1ns / 1ps

// Holds the bytes of one input transaction and hands them out one per cycle while not stalled.
module cfb_emit_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  cfb_pkg::emit_load_t   load_data,
  output cfb_pkg::emit_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cfb_pkg::out_item_t    out_data
);

  logic [cfb_pkg::BUF_DEPTH-1:0][7:0] bytes_r;
  logic [cfb_pkg::CNT_W-1:0]          cnt_r;
  logic [cfb_pkg::CNT_W-1:0]          idx_r;
  logic [cfb_pkg::CNT_W-1:0]          idx_nxt;
  logic                               eof_r;
  logic                               take;
  logic                               last;

  assign idx_nxt   = cfb_pkg::CNT_W'(idx_r + 1'b1);
  assign out_valid = (idx_r != cnt_r);
  assign take      = out_valid && !out_stall;
  assign last      = (idx_nxt == cnt_r);

  // The buffer is free when empty or when its last byte leaves this cycle.
  assign status.free = !out_valid || (take && last);

  assign out_data.out_byte     = bytes_r[idx_r];
  assign out_data.end_of_frame = eof_r && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      eof_r <= 1'b0;
    end else if (load) begin
      cnt_r <= load_data.count;
      idx_r <= '0;
      eof_r <= load_data.eof;
    end else if (take) begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= load_data.bytes;
    end
  end

endmodule

>>> sv/command_frame_builder_crc16.sv
`timescale 1ns / 1ps

// Command frame builder with CRC-16. Each input transaction carries one payload
// byte; the first byte of a frame also carries the payload length and a resync
// flag. The block emits the start byte 0x7F, a sequence byte (0x80 or 0x00,
// flipping each frame, cleared first by resync), the length, the payload and a
// CRC-16 (polynomial 0x8005, seed 0xFFFF, MSB first, over sequence, length and
// payload) sent low byte then high byte, with end_of_frame on the high byte. A
// first byte with zero length is accepted and dropped without effect. Rate: an
// input transaction is taken in every cycle while the output is not stalled and
// a frame is in its middle bytes; the first byte of a frame puts four bytes out
// (six for a one-byte frame) and the last byte three. The rate is set by the
// output port, one byte per cycle while not stalled: the next input is taken
// in the same cycle as the last pending output byte of the previous one.
module command_frame_builder_crc16 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfb_pkg::out_item_t out_data
);

`include "assert_macros.svh"

  // Frame state: sequence toggle, running CRC and bytes still expected.
  logic        seq_toggle_r;
  logic        seq_toggle_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  bytes_left_r;
  logic [7:0]  bytes_left_nxt;

  logic                  accept;
  logic                  first;
  logic                  drop;
  logic                  update;
  logic [15:0]           crc_mid;
  logic [7:0]            left_cur;
  logic [7:0]            seq_byte;
  cfb_pkg::emit_load_t   load_data;
  cfb_pkg::emit_status_t status;
  logic                  opened;
  logic                  sof_out;

  assign in_stall = !status.free;
  assign accept   = in_valid && !in_stall;
  assign first    = (bytes_left_r == 8'd0);
  // A first byte with zero length leaves everything as it was.
  assign drop     = first && (in_data.frame_length == 8'd0);
  assign update   = accept && !drop;

  // All the work for one transaction is done here, in a single pass, and is
  // captured in the emit buffer together with the new frame state.
  always_comb begin
    seq_toggle_nxt = seq_toggle_r;
    seq_byte       = cfb_pkg::SEQ_CLEAR;
    crc_mid        = crc_r;
    left_cur       = bytes_left_r;
    if (first) begin
      // Resync clears the toggle before it flips for the new frame.
      seq_toggle_nxt = !(seq_toggle_r && !in_data.resync);
      seq_byte       = seq_toggle_nxt ? cfb_pkg::SEQ_SET : cfb_pkg::SEQ_CLEAR;
      crc_mid        = cfb_pkg::crc_byte(seq_toggle_nxt ? cfb_pkg::CRC_AFTER_SEQ_SET
                                                        : cfb_pkg::CRC_AFTER_SEQ_CLEAR,
                                         in_data.frame_length);
      left_cur       = in_data.frame_length;
    end
    crc_nxt        = cfb_pkg::crc_byte(crc_mid, in_data.data_byte);
    bytes_left_nxt = 8'(left_cur - 8'd1);

    load_data.bytes = '0;
    load_data.eof   = (bytes_left_nxt == 8'd0);
    if (drop) begin
      load_data.count = '0;
      load_data.eof   = 1'b0;
    end else if (first) begin
      load_data.bytes[0] = cfb_pkg::SOF_BYTE;
      load_data.bytes[1] = seq_byte;
      load_data.bytes[2] = in_data.frame_length;
      load_data.bytes[3] = in_data.data_byte;
      load_data.bytes[4] = crc_nxt[7:0];
      load_data.bytes[5] = crc_nxt[15:8];
      load_data.count    = load_data.eof ? cfb_pkg::CNT_W'(6) : cfb_pkg::CNT_W'(4);
    end else begin
      load_data.bytes[0] = in_data.data_byte;
      load_data.bytes[1] = crc_nxt[7:0];
      load_data.bytes[2] = crc_nxt[15:8];
      load_data.count    = load_data.eof ? cfb_pkg::CNT_W'(3) : cfb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_toggle_r <= 1'b0;
      crc_r        <= cfb_pkg::CRC_SEED;
      bytes_left_r <= 8'd0;
    end else if (update) begin
      seq_toggle_r <= seq_toggle_nxt;
      crc_r        <= crc_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // The emit buffer parts the input from the output: the next transaction is
  // loaded in the cycle that the last waiting byte is taken.
  cfb_emit_buf u_emit_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (load_data),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A frame is opened by an accepted first byte with a non-zero length.
  assign opened  = update && first;
  assign sof_out = out_valid && (out_data.out_byte == cfb_pkg::SOF_BYTE);

  // The closing CRC byte can only be shown once the frame has no bytes left.
  `ASSERT_PROP(a_eof_idle, clk, rst_n, out_data.end_of_frame |-> first, "frame closed early")

  // A frame opened from idle starts with the start byte on the next cycle.
  `ASSERT_PROP(a_sof_first, clk, rst_n, opened |=> sof_out, "frame without start byte")

  // Input is only held off while bytes are waiting at the output.
  `ASSERT_ALWAYS(a_stall_cause, clk, rst_n, !(in_stall && !out_valid), "stall with empty output")

endmodule
